// ----- rtl/fm0_reply_bit_decode_crc_check_core_macros.svh -----
// assertion macros shared by the fm0 reply decoder modules
`ifndef FM0_REPLY_BIT_DECODE_CRC_CHECK_CORE_MACROS_SVH
`define FM0_REPLY_BIT_DECODE_CRC_CHECK_CORE_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define FM0_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fm0 decoder check failed");

// next-cycle implication, sampled on clock, off during reset
`define FM0_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fm0 decoder check failed");

`endif

// ----- rtl/fm0_pkg.sv -----
// shared types and constants of the fm0 reply bit decoder
package fm0_pkg;

   localparam int SAMPLE_WIDTH    = 16;
   localparam int CHAN_WIDTH      = 16;
   localparam int LONG_FRAME_BITS = 128;
   localparam int FIFO_DEPTH      = 4;

   localparam int RN_BITS        = 16;
   localparam int HND_FRAME_BITS = 32;
   localparam int CHECK_BITS     = 16;
   localparam int PAYLOAD_WIDTH  = 32;
   localparam int POS_WIDTH      = 7;

   localparam logic [15:0] CRC_POLY   = 16'h1021;
   localparam logic [15:0] CRC_PRESET = 16'hFFFF;

   localparam logic [1:0] KIND_RN     = 2'd0;
   localparam logic [1:0] KIND_ID     = 2'd1;
   localparam logic [1:0] KIND_HANDLE = 2'd2;

   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [1:0] CSR_FRAME_KIND = 2'd0;
   localparam logic [1:0] CSR_CHAN_EST_I = 2'd1;
   localparam logic [1:0] CSR_CHAN_EST_Q = 2'd2;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] first_half_i;
      logic signed [SAMPLE_WIDTH-1:0] first_half_q;
      logic signed [SAMPLE_WIDTH-1:0] second_half_i;
      logic signed [SAMPLE_WIDTH-1:0] second_half_q;
   } req_type;

   typedef struct packed {
      logic                     decoded_bit;
      logic [POS_WIDTH-1:0]     bit_position;
      logic                     frame_last;
      logic                     crc_ok;
      logic [PAYLOAD_WIDTH-1:0] payload_word;
   } rsp_type;

   typedef struct packed {
      logic [1:0]                   frame_kind;
      logic signed [CHAN_WIDTH-1:0] chan_est_i;
      logic signed [CHAN_WIDTH-1:0] chan_est_q;
   } cfg_type;

endpackage

// ----- rtl/fm0_reply_bit_decode_crc_check_core.sv -----
// top level of the fm0 tag reply bit decoder with crc-16 check
//
//   port group   direction   handshake                  word
//   req_         in          req_valid / req_ready      fm0_pkg::req_type, one bit period
//   rsp_         out         rsp_valid / rsp_ready      fm0_pkg::rsp_type, one decoded bit
//   csr (apb)    in/out      psel, penable, pready      32-bit registers at 0x0, 0x4, 0x8
//
// one word per cycle sustained while results are taken; each taken word passes the
// difference stage, multiplier stage, queue and sequencer output register
// synchronous reset clears control and frame state, no clearing pass is needed
// with rsp_ready low the level queue fills, then req_ready drops until a result is taken
module fm0_reply_bit_decode_crc_check_core #(
   parameter int LONG_FRAME_BITS = fm0_pkg::LONG_FRAME_BITS,
   parameter int FIFO_DEPTH      = fm0_pkg::FIFO_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  fm0_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output fm0_pkg::rsp_type                    rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [fm0_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  logic [fm0_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic [fm0_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic                                pready
);

   fm0_pkg::cfg_type cfg;
   logic             push;
   logic             push_level;
   logic             pop;
   logic             pop_level;
   logic             fifo_empty;
   logic             fifo_full;

   fm0_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   fm0_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .cfg        (cfg),
      .fifo_full  (fifo_full),
      .push       (push),
      .push_level (push_level)
   );

   fm0_fifo #(
      .Depth (FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_level),
      .pop       (pop),
      .pop_data  (pop_level),
      .empty     (fifo_empty),
      .full      (fifo_full)
   );

   fm0_back #(
      .LongFrameBits (LONG_FRAME_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .fifo_empty (fifo_empty),
      .pop_level  (pop_level),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

// ----- rtl/fm0_csr.sv -----
// configuration registers behind the apb-style port
module fm0_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [fm0_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  logic [fm0_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic [fm0_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic                                pready,
   output fm0_pkg::cfg_type                    cfg
);

   logic [1:0]                            frame_kind_ff;
   logic signed [fm0_pkg::CHAN_WIDTH-1:0] chan_est_i_ff;
   logic signed [fm0_pkg::CHAN_WIDTH-1:0] chan_est_q_ff;
   logic                                  wr_en;
   logic [1:0]                            reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_kind_ff <= fm0_pkg::KIND_RN;
         chan_est_i_ff <= '0;
         chan_est_q_ff <= '0;
      end else if (wr_en) begin
         unique case (reg_idx)
            fm0_pkg::CSR_FRAME_KIND: frame_kind_ff <= pwdata[1:0];
            fm0_pkg::CSR_CHAN_EST_I: chan_est_i_ff <= pwdata[fm0_pkg::CHAN_WIDTH-1:0];
            fm0_pkg::CSR_CHAN_EST_Q: chan_est_q_ff <= pwdata[fm0_pkg::CHAN_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (reg_idx)
         fm0_pkg::CSR_FRAME_KIND: prdata = {30'b0, frame_kind_ff};
         fm0_pkg::CSR_CHAN_EST_I: prdata = {16'b0, chan_est_i_ff};
         fm0_pkg::CSR_CHAN_EST_Q: prdata = {16'b0, chan_est_q_ff};
         default: prdata = '0;
      endcase
   end

   assign cfg.frame_kind = frame_kind_ff;
   assign cfg.chan_est_i = chan_est_i_ff;
   assign cfg.chan_est_q = chan_est_q_ff;

endmodule

// ----- rtl/fm0_front.sv -----
// front pipeline: sample difference, projection onto channel estimate, level slice
`include "fm0_reply_bit_decode_crc_check_core_macros.svh"

module fm0_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  fm0_pkg::req_type req_data,
   input  fm0_pkg::cfg_type cfg,
   input  logic             fifo_full,
   output logic             push,
   output logic             push_level
);

   localparam int DiffW = fm0_pkg::SAMPLE_WIDTH + 1;
   localparam int ProdW = DiffW + fm0_pkg::CHAN_WIDTH;
   localparam int SumW  = ProdW + 1;

   logic                    adv;
   logic                    v1_ff;
   logic                    v2_ff;
   logic signed [DiffW-1:0] di_ff, dq_ff;
   logic signed [DiffW-1:0] di_in, dq_in;
   logic signed [ProdW-1:0] prod_i_ff, prod_q_ff;
   logic signed [ProdW-1:0] prod_i_in, prod_q_in;
   logic signed [SumW-1:0]  proj;

   // whole pipe holds while the last stage cannot hand off
   assign adv       = !(v2_ff && fifo_full);
   assign req_ready = adv;

   assign di_in = $signed({req_data.first_half_i[fm0_pkg::SAMPLE_WIDTH-1],
                           req_data.first_half_i})
                - $signed({req_data.second_half_i[fm0_pkg::SAMPLE_WIDTH-1],
                           req_data.second_half_i});
   assign dq_in = $signed({req_data.first_half_q[fm0_pkg::SAMPLE_WIDTH-1],
                           req_data.first_half_q})
                - $signed({req_data.second_half_q[fm0_pkg::SAMPLE_WIDTH-1],
                           req_data.second_half_q});

   assign prod_i_in = di_ff * cfg.chan_est_i;
   assign prod_q_in = dq_ff * cfg.chan_est_q;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         di_ff     <= di_in;
         dq_ff     <= dq_in;
         prod_i_ff <= prod_i_in;
         prod_q_ff <= prod_q_in;
      end
   end

   assign proj = SumW'(prod_i_ff) + SumW'(prod_q_ff);

   // strictly positive projection is level +1
   assign push_level = !proj[SumW-1] && (proj != '0);
   assign push       = v2_ff && adv;

   `FM0_ASSERT_NXT(a_front_hold, v2_ff && !adv, v2_ff && $stable(prod_i_ff) && $stable(prod_q_ff))

endmodule

// ----- rtl/fm0_fifo.sv -----
// short level queue between the front pipeline and the frame sequencer
`include "fm0_reply_bit_decode_crc_check_core_macros.svh"

module fm0_fifo #(
   parameter int Depth = fm0_pkg::FIFO_DEPTH
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  logic push_data,
   input  logic pop,
   output logic pop_data,
   output logic empty,
   output logic full
);

   localparam int PtrW = $clog2(Depth);
   localparam int CntW = $clog2(Depth + 1);

   logic [Depth-1:0] mem_ff;
   logic [PtrW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0]  count_ff;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CntW'(Depth));
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CntW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CntW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `FM0_ASSERT_IMP(a_fifo_no_overflow, push, !full)

endmodule

// ----- rtl/fm0_back.sv -----
// frame sequencer: fm0 bit decision, frame length, crc-16 check, payload capture
`include "fm0_reply_bit_decode_crc_check_core_macros.svh"

module fm0_back #(
   parameter int LongFrameBits = fm0_pkg::LONG_FRAME_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  fm0_pkg::cfg_type cfg,
   input  logic             fifo_empty,
   input  logic             pop_level,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output fm0_pkg::rsp_type rsp_data
);

   localparam int CntW  = $clog2(LongFrameBits);
   localparam int LenW  = CntW + 2;
   localparam int PosXW = (CntW > fm0_pkg::POS_WIDTH) ? CntW : fm0_pkg::POS_WIDTH;
   localparam bit CapOk = (LongFrameBits >= 48);
   localparam int CapLo = CapOk ? LongFrameBits - 48 : 0;
   localparam int CapHi = LongFrameBits - 17;
   localparam int PayW  = fm0_pkg::PAYLOAD_WIDTH;

   logic                 prev_ff;
   logic [CntW-1:0]      cnt_ff;
   logic [15:0]          crc_ff, crc_in;
   logic [15:0]          chk_ff, chk_in;
   logic [PayW-1:0]      pay_ff, pay_in;
   logic                 out_valid_ff;
   fm0_pkg::rsp_type     out_ff, out_in;

   logic                 take;
   logic                 dbit;
   logic [LenW-1:0]      pos_w;
   logic [LenW-1:0]      len;
   logic                 with_crc;
   logic                 last;
   logic                 cap;
   logic [PosXW-1:0]     pos_x;

   assign take  = !out_valid_ff || rsp_ready;
   assign pop   = !fifo_empty && take;
   assign dbit  = pop_level ^ prev_ff;
   assign pos_w = LenW'(cnt_ff);
   assign pos_x = PosXW'(cnt_ff);

   always_comb begin
      unique case (cfg.frame_kind)
         fm0_pkg::KIND_ID: begin
            len      = LenW'(LongFrameBits);
            with_crc = 1'b1;
         end
         fm0_pkg::KIND_HANDLE: begin
            len      = LenW'(fm0_pkg::HND_FRAME_BITS);
            with_crc = 1'b1;
         end
         default: begin
            len      = LenW'(fm0_pkg::RN_BITS);
            with_crc = 1'b0;
         end
      endcase
   end

   assign last = (pos_w >= len - LenW'(1));

   // identity frames keep a window near the end, others keep the first bits
   always_comb begin
      if (cfg.frame_kind == fm0_pkg::KIND_ID) begin
         cap = CapOk && (pos_w >= LenW'(CapLo)) && (pos_w <= LenW'(CapHi));
      end else begin
         cap = (pos_w < LenW'(fm0_pkg::RN_BITS));
      end
      pay_in = cap ? {pay_ff[PayW-2:0], dbit} : pay_ff;
   end

   always_comb begin
      crc_in = crc_ff;
      chk_in = chk_ff;
      if (with_crc) begin
         if (pos_w + LenW'(fm0_pkg::CHECK_BITS) < len) begin
            crc_in = {crc_ff[14:0], 1'b0} ^ ((crc_ff[15] ^ dbit) ? fm0_pkg::CRC_POLY : 16'h0000);
         end else begin
            chk_in = {chk_ff[14:0], dbit};
         end
      end
   end

   always_comb begin
      out_in.decoded_bit  = dbit;
      out_in.bit_position = pos_x[fm0_pkg::POS_WIDTH-1:0];
      out_in.frame_last   = last;
      out_in.crc_ok       = last && (with_crc ? (chk_in == ~crc_in) : 1'b1);
      out_in.payload_word = last ? pay_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         prev_ff      <= 1'b1;
         cnt_ff       <= '0;
         crc_ff       <= fm0_pkg::CRC_PRESET;
         chk_ff       <= '0;
         pay_ff       <= '0;
      end else begin
         if (take) begin
            out_valid_ff <= pop;
         end
         if (pop) begin
            if (last) begin
               prev_ff <= 1'b1;
               cnt_ff  <= '0;
               crc_ff  <= fm0_pkg::CRC_PRESET;
               chk_ff  <= '0;
               pay_ff  <= '0;
            end else begin
               prev_ff <= pop_level;
               cnt_ff  <= cnt_ff + CntW'(1);
               crc_ff  <= crc_in;
               chk_ff  <= chk_in;
               pay_ff  <= pay_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   `FM0_ASSERT_NXT(a_back_restart, pop && last, (cnt_ff == '0) && prev_ff && (crc_ff == fm0_pkg::CRC_PRESET))
   `FM0_ASSERT_IMP(a_back_crc_on_last, out_valid_ff, !out_ff.crc_ok || out_ff.frame_last)

endmodule

// ----- test/tb.sv -----
// testbench for the fm0 reply bit decoder: bit-level scoreboard class and stimulus top

class fm0_frame_tracker;
   // register copies
   logic [1:0]                            kind;
   logic signed [fm0_pkg::CHAN_WIDTH-1:0] chan_i;
   logic signed [fm0_pkg::CHAN_WIDTH-1:0] chan_q;
   // frame state
   bit                                    prev_level;
   logic [7:0]                            bit_cnt;
   logic [15:0]                           crc;
   logic [15:0]                           rx_check;
   logic [31:0]                           payload_shift;

   fm0_pkg::rsp_type expected_bits[$];
   int unsigned      words_taken;
   int unsigned      frames_closed;
   int unsigned      checks_good;
   int unsigned      mismatches;
   int unsigned      orphans;

   function new();
      kind = fm0_pkg::KIND_RN;
      chan_i = '0;
      chan_q = '0;
      restart_frame();
   endfunction

   function void restart_frame();
      prev_level = 1'b1;
      bit_cnt = '0;
      crc = fm0_pkg::CRC_PRESET;
      rx_check = '0;
      payload_shift = '0;
   endfunction

   function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
         fm0_pkg::CSR_FRAME_KIND: kind = value[1:0];
         fm0_pkg::CSR_CHAN_EST_I: chan_i = value[15:0];
         fm0_pkg::CSR_CHAN_EST_Q: chan_q = value[15:0];
         default: ;
      endcase
   endfunction

   static function logic [15:0] crc_next(logic [15:0] c, bit b);
      bit fb;
      fb = c[15] ^ b;
      return {c[14:0], 1'b0} ^ (fb ? fm0_pkg::CRC_POLY : 16'h0000);
   endfunction

   function int unsigned frame_len();
      case (kind)
         fm0_pkg::KIND_ID:     return fm0_pkg::LONG_FRAME_BITS;
         fm0_pkg::KIND_HANDLE: return fm0_pkg::HND_FRAME_BITS;
         default:              return fm0_pkg::RN_BITS;
      endcase
   endfunction

   // level +1 only for a strictly positive projection onto the channel
   function bit level_of(fm0_pkg::req_type w);
      longint di, dq, proj;
      di = longint'($signed(w.first_half_i)) - longint'($signed(w.second_half_i));
      dq = longint'($signed(w.first_half_q)) - longint'($signed(w.second_half_q));
      proj = di * longint'(chan_i) + dq * longint'(chan_q);
      return proj > 0;
   endfunction

   function void note_word(fm0_pkg::req_type w);
      fm0_pkg::rsp_type r;
      bit               lvl, b, with_crc, last_bit;
      int unsigned      len, pos;
      lvl = level_of(w);
      b = (lvl != prev_level);
      pos = bit_cnt;
      len = frame_len();
      with_crc = (kind == fm0_pkg::KIND_ID) || (kind == fm0_pkg::KIND_HANDLE);
      last_bit = (pos >= len - 1);
      if (kind == fm0_pkg::KIND_ID) begin
         if (pos >= fm0_pkg::LONG_FRAME_BITS - 48 && pos <= fm0_pkg::LONG_FRAME_BITS - 17)
            payload_shift = {payload_shift[30:0], b};
      end else if (pos < fm0_pkg::RN_BITS) begin
         payload_shift = {payload_shift[30:0], b};
      end
      if (with_crc) begin
         if (pos + fm0_pkg::CHECK_BITS < len)
            crc = crc_next(crc, b);
         else
            rx_check = {rx_check[14:0], b};
      end
      r = '0;
      r.decoded_bit = b;
      r.bit_position = pos[fm0_pkg::POS_WIDTH-1:0];
      r.frame_last = last_bit;
      if (last_bit) begin
         r.crc_ok = with_crc ? (rx_check == ~crc) : 1'b1;
         r.payload_word = payload_shift;
         frames_closed++;
         if (r.crc_ok) checks_good++;
         restart_frame();
      end else begin
         prev_level = lvl;
         bit_cnt = 8'(pos + 1);
      end
      expected_bits.insert(expected_bits.size(), r);
      words_taken++;
   endfunction

   function void check_bit(fm0_pkg::rsp_type got);
      fm0_pkg::rsp_type want;
      if (expected_bits.size() == 0) begin
         orphans++;
         if (orphans + mismatches <= 10)
            $display("unexpected result word: bit %0d pos %0d last %0d ok %0d payload %h",
                     got.decoded_bit, got.bit_position, got.frame_last, got.crc_ok,
                     got.payload_word);
         return;
      end
      want = expected_bits.pop_front();
      if (got.decoded_bit !== want.decoded_bit || got.bit_position !== want.bit_position ||
          got.frame_last !== want.frame_last || got.crc_ok !== want.crc_ok ||
          got.payload_word !== want.payload_word) begin
         mismatches++;
         if (orphans + mismatches <= 10) begin
            $display("mismatch: exp bit %0d pos %0d last %0d ok %0d payload %h",
                     want.decoded_bit, want.bit_position, want.frame_last, want.crc_ok,
                     want.payload_word);
            $display("          got bit %0d pos %0d last %0d ok %0d payload %h",
                     got.decoded_bit, got.bit_position, got.frame_last, got.crc_ok,
                     got.payload_word);
         end
      end
   endfunction
endclass

module tb;
   localparam logic [1:0] KIND_UNDEF    = 2'd3;
   localparam int         FRAME_CLEAN   = 0;
   localparam int         FRAME_FLIPPED = 1;
   localparam int         FRAME_NOISE   = 2;
   localparam int         WORD_TARGET   = 1200;

   logic                               clock;
   logic                               reset;
   logic                               req_valid;
   logic                               req_ready;
   fm0_pkg::req_type                   req_data;
   logic                               rsp_valid;
   logic                               rsp_ready;
   fm0_pkg::rsp_type                   rsp_data;
   logic                               psel;
   logic                               penable;
   logic                               pwrite;
   logic [fm0_pkg::CSR_ADDR_WIDTH-1:0] paddr;
   logic [fm0_pkg::CSR_DATA_WIDTH-1:0] pwdata;
   logic [fm0_pkg::CSR_DATA_WIDTH-1:0] prdata;
   logic                               pready;

   fm0_frame_tracker tracker;
   bit               source_gaps;
   bit               sink_gaps;
   int               sink_hold;

   fm0_reply_bit_decode_crc_check_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("FAIL");
      $finish;
   end

   // result side: check accepted words, stall at random or for a requested hold-off
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) tracker.check_bit(rsp_data);
         if (sink_hold > 0) begin
            rsp_ready <= 1'b0;
            sink_hold--;
         end else begin
            rsp_ready <= !(sink_gaps && $urandom_range(99) < 21);
         end
      end
   end

   function automatic fm0_pkg::req_type any_word();
      fm0_pkg::req_type w;
      w = {$urandom, $urandom};
      if ($urandom_range(3) == 0) begin
         w.first_half_i = 16'($urandom_range(16) - 8);
         w.first_half_q = 16'($urandom_range(16) - 8);
         w.second_half_i = 16'($urandom_range(16) - 8);
         w.second_half_q = 16'($urandom_range(16) - 8);
      end
      return w;
   endfunction

   // with a zero channel estimate no word reaches level +1, so give up after a while
   function automatic fm0_pkg::req_type word_for_level(bit want);
      fm0_pkg::req_type w;
      w = any_word();
      for (int tries = 0; tries < 200 && tracker.level_of(w) != want; tries++)
         w = any_word();
      return w;
   endfunction

   function automatic fm0_pkg::req_type mk_word(logic [15:0] fi, logic [15:0] fq,
                                                logic [15:0] si, logic [15:0] sq);
      fm0_pkg::req_type w;
      w.first_half_i = fi;
      w.first_half_q = fq;
      w.second_half_i = si;
      w.second_half_q = sq;
      return w;
   endfunction

   function automatic logic [15:0] pick_chan();
      case ($urandom_range(5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0001;
         3: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_word(input fm0_pkg::req_type w);
      while (source_gaps && $urandom_range(99) < 21) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_word(w);
   endtask

   task automatic stop_sending();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (tracker.expected_bits.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= {16'($urandom), value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      tracker.set_reg(idx, {16'h0000, value});
      @(posedge clock);
   endtask

   task automatic send_frame(input int unsigned cut, input int flavor);
      bit          frame_bits[fm0_pkg::LONG_FRAME_BITS];
      logic [15:0] crc;
      bit          lvl;
      bit          checked;
      int unsigned len, body, idx;
      len = tracker.frame_len();
      checked = (tracker.kind == fm0_pkg::KIND_ID) || (tracker.kind == fm0_pkg::KIND_HANDLE);
      body = checked ? len - fm0_pkg::CHECK_BITS : len;
      crc = fm0_pkg::CRC_PRESET;
      for (int k = 0; k < body; k++) begin
         frame_bits[k] = 1'($urandom_range(1));
         crc = tracker.crc_next(crc, frame_bits[k]);
      end
      if (checked)
         for (int k = 0; k < fm0_pkg::CHECK_BITS; k++)
            frame_bits[body + k] = ~crc[fm0_pkg::CHECK_BITS - 1 - k];
      if (flavor == FRAME_FLIPPED) begin
         idx = $urandom_range(len - 1);
         frame_bits[idx] = ~frame_bits[idx];
      end
      // level toggles on a one, starting from +1
      lvl = 1'b1;
      for (int k = 0; k < cut; k++) begin
         lvl = lvl ^ frame_bits[k];
         send_word(flavor == FRAME_NOISE ? any_word() : word_for_level(lvl));
      end
   endtask

   initial begin
      logic [1:0]  kind;
      int          phase;
      int unsigned len, n_frames, pick;
      tracker = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      source_gaps = 1'b1;
      sink_gaps = 1'b1;
      sink_hold = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes and zero projection on a random number frame
      write_reg(fm0_pkg::CSR_FRAME_KIND, 16'(fm0_pkg::KIND_RN));
      write_reg(fm0_pkg::CSR_CHAN_EST_I, 16'h7FFF);
      write_reg(fm0_pkg::CSR_CHAN_EST_Q, 16'h8000);
      send_word(mk_word(16'h0000, 16'h0000, 16'h0000, 16'h0000));
      send_word(mk_word(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000));
      send_word(mk_word(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF));
      send_word(mk_word(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000));
      send_word(mk_word(16'h8000, 16'h0000, 16'h0000, 16'h0000));
      send_word(mk_word(16'h0000, 16'h8000, 16'h0000, 16'h0000));
      send_word(mk_word(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
      send_word(mk_word(16'h8000, 16'h8000, 16'h8000, 16'h8000));
      send_word(mk_word(16'h0000, 16'h0000, 16'h7FFF, 16'h0000));
      send_word(mk_word(16'h0000, 16'h0000, 16'h0000, 16'h7FFF));
      send_word(mk_word(16'h0001, 16'h0001, 16'h0000, 16'h0000));
      send_word(mk_word(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000));
      send_word(mk_word(16'h7FFF, 16'h0000, 16'h8000, 16'h0000));
      send_word(mk_word(16'h0000, 16'h7FFF, 16'h0000, 16'h8000));
      send_word(mk_word(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF));
      send_word(mk_word(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000));
      // undefined kind behaves as a random number frame
      stop_sending();
      wait_drained();
      write_reg(fm0_pkg::CSR_FRAME_KIND, 16'(KIND_UNDEF));
      send_word(mk_word(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000));
      send_word(mk_word(16'h0001, 16'h0001, 16'h0000, 16'h0000));
      send_word(mk_word(16'h1234, 16'h5678, 16'h1234, 16'h5678));
      send_word(mk_word(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000));
      send_word(mk_word(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF));
      send_word(mk_word(16'h0000, 16'h0000, 16'h0000, 16'h0000));

      phase = 0;
      while (tracker.words_taken < WORD_TARGET) begin
         stop_sending();
         wait_drained();
         case (phase)
            0: kind = fm0_pkg::KIND_ID;
            1: kind = fm0_pkg::KIND_HANDLE;
            2: kind = fm0_pkg::KIND_RN;
            3: kind = fm0_pkg::KIND_HANDLE;
            default: begin
               pick = $urandom_range(9);
               kind = (pick < 3) ? fm0_pkg::KIND_ID : (pick < 6) ? fm0_pkg::KIND_HANDLE :
                      (pick < 8) ? fm0_pkg::KIND_RN : KIND_UNDEF;
            end
         endcase
         // a kind change can land in the middle of a cut-off frame
         write_reg(fm0_pkg::CSR_FRAME_KIND, 16'(kind));
         if (phase == 0) begin
            write_reg(fm0_pkg::CSR_CHAN_EST_I, 16'h8000);
            write_reg(fm0_pkg::CSR_CHAN_EST_Q, 16'h7FFF);
         end else if (phase == 3) begin
            write_reg(fm0_pkg::CSR_CHAN_EST_I, 16'h0000);
            write_reg(fm0_pkg::CSR_CHAN_EST_Q, 16'h0000);
         end else if (phase < 5 || $urandom_range(1)) begin
            write_reg(fm0_pkg::CSR_CHAN_EST_I, pick_chan());
            write_reg(fm0_pkg::CSR_CHAN_EST_Q, pick_chan());
         end
         source_gaps = (phase != 1);
         sink_gaps = (phase != 1);
         if (phase == 2) sink_hold = 80;

         // finish whatever frame is still open so the next ones start aligned
         len = tracker.frame_len();
         if (tracker.bit_cnt != 0) begin
            n_frames = (tracker.bit_cnt >= len - 1) ? 1 : len - tracker.bit_cnt;
            repeat (n_frames) send_word(any_word());
         end

         n_frames = (kind == fm0_pkg::KIND_ID) ? $urandom_range(1, 2) : $urandom_range(3, 8);
         repeat (n_frames) begin
            pick = $urandom_range(9);
            send_frame(len, (pick == 0) ? FRAME_NOISE :
                            (pick < 3) ? FRAME_FLIPPED : FRAME_CLEAN);
         end
         if ($urandom_range(9) < 3)
            send_frame($urandom_range(1, len - 1), FRAME_CLEAN);
         phase++;
      end

      stop_sending();
      wait_drained();
      repeat (10) @(posedge clock);
      $display("run covered %0d words over %0d phases of frame kind and channel settings",
               tracker.words_taken, phase);
      $display("%0d frames closed, %0d with a matching check, %0d left waiting",
               tracker.frames_closed, tracker.checks_good, tracker.expected_bits.size());
      if (tracker.mismatches == 0 && tracker.orphans == 0 &&
          tracker.expected_bits.size() == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches, %0d unexpected results", tracker.mismatches,
                  tracker.orphans);
         $display("FAIL");
      end
      $finish;
   end
endmodule
